@@ rtl/complex_multiframe_echo_filter_macros.svh @@
// Assertion macros for the complex multi-frame echo filter.
`ifndef COMPLEX_MULTIFRAME_ECHO_FILTER_MACROS_SVH
`define COMPLEX_MULTIFRAME_ECHO_FILTER_MACROS_SVH

// Same-cycle implication.
`define CMEF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CMEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cmef_pkg.sv @@
// Shared types and constants for the complex multi-frame echo filter.
`timescale 1ns / 1ps

package cmef_pkg;

	localparam int SPEC_W    = 24;
	localparam int TAP_W     = 16;
	localparam int BIN_IN_W  = 10;
	localparam int TIDX_W    = 4;
	localparam int PROD_W    = SPEC_W + TAP_W;
	localparam int FRAC_BITS = 11;
	localparam int SPEC_MAX  = 8388607;
	localparam int SPEC_MIN  = -8388608;

	localparam logic OP_TAP = 1'b0;
	localparam logic OP_BIN = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input word
		logic tap_wr;    // write tap pair
		logic slot_adv;  // advance ring slot (frame start)
		logic mod_q;     // bin quotient step
		logic mod_r;     // bin remainder step, accumulator init
		logic ring_wr;   // store reference at current slot
		logic rd_step;   // one ring read + tap fetch
		logic clr_wr;    // clear sweep write
		logic out_load;  // load output register
		logic bypass;    // pass mic through
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_bin;
		logic frame_start;
		logic clr_last;
		logic k_last;
		logic pipe_busy;
	} stat_t;

endpackage

@@ rtl/cmef_dp.sv @@
// Datapath: input capture, tap store, reference ring memory, complex MAC, rounding.
`timescale 1ns / 1ps

module cmef_dp #(
	parameter int FILTER_ORDER = 5,
	parameter int MAX_BINS     = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cmef_pkg::cmd_t                         cmd,
	output cmef_pkg::stat_t                        stat,
	input  logic                                   opcode,
	input  logic        [cmef_pkg::TIDX_W-1:0]     tap_index,
	input  logic signed [cmef_pkg::TAP_W-1:0]      tap_real,
	input  logic signed [cmef_pkg::TAP_W-1:0]      tap_imag,
	input  logic        [cmef_pkg::BIN_IN_W-1:0]   bin_index,
	input  logic                                   frame_start,
	input  logic signed [cmef_pkg::SPEC_W-1:0]     mic_real,
	input  logic signed [cmef_pkg::SPEC_W-1:0]     mic_imag,
	input  logic signed [cmef_pkg::SPEC_W-1:0]     ref_real,
	input  logic signed [cmef_pkg::SPEC_W-1:0]     ref_imag,
	output logic        [cmef_pkg::BIN_IN_W-1:0]   out_bin,
	output logic signed [cmef_pkg::SPEC_W-1:0]     enh_real,
	output logic signed [cmef_pkg::SPEC_W-1:0]     enh_imag,
	output logic                                   saturated
);
	import cmef_pkg::*;

	localparam int DEPTH  = FILTER_ORDER * MAX_BINS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IDX_W  = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
	localparam int BIN_W  = $clog2(MAX_BINS);
	localparam int SUM_W  = 42 + $clog2(FILTER_ORDER);
	localparam int RCP_SH = 22;
	localparam int RECIP  = (2**RCP_SH + MAX_BINS - 1) / MAX_BINS;
	localparam int QP_W   = BIN_IN_W + RCP_SH + 1;
	localparam int QM_W   = BIN_IN_W + 13;
	localparam logic [ADDR_W-1:0] STEP_M   = ADDR_W'(MAX_BINS);
	localparam logic [ADDR_W-1:0] WRAP_M   = ADDR_W'((FILTER_ORDER - 1) * MAX_BINS);
	localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(DEPTH - 1);
	localparam logic [IDX_W-1:0]  LAST_K   = IDX_W'(FILTER_ORDER - 1);
	localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'(SPEC_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO   = SUM_W'(SPEC_MIN);

	// captured input word
	logic                       op_q;
	logic        [TIDX_W-1:0]   tidx_q;
	logic signed [TAP_W-1:0]    tre_q, tim_q;
	logic        [BIN_IN_W-1:0] bin_q;
	logic                       fs_q;
	logic signed [SPEC_W-1:0]   mre_q, mim_q, rre_q, rim_q;

	logic signed [TAP_W-1:0]    tap_re_q [FILTER_ORDER];
	logic signed [TAP_W-1:0]    tap_im_q [FILTER_ORDER];

	logic [2*SPEC_W-1:0]        ring_mem [DEPTH];

	logic [IDX_W-1:0]           slot_q, rd_slot_q, k_q;
	logic [ADDR_W-1:0]          slot_base_q, rd_addr_q, clr_addr_q;
	logic [BIN_IN_W-1:0]        binq_q;
	logic [BIN_W-1:0]           b_q;
	logic                       valid_s1, valid_s2;

	logic signed [SPEC_W-1:0]   ref_re_s1, ref_im_s1;
	logic signed [TAP_W-1:0]    tap_re_s1, tap_im_s1;
	logic signed [PROD_W-1:0]   pr_rr_s2, pr_ii_s2, pr_ri_s2, pr_ir_s2;
	logic signed [SUM_W-1:0]    acc_re_q, acc_im_q;

	logic [QP_W-1:0]            qprod;
	logic [QM_W-1:0]            qm, rem;
	logic [ADDR_W-1:0]          wr_addr, mem_addr;
	logic [2*SPEC_W-1:0]        mem_wdata;
	logic                       mem_we;
	logic signed [SUM_W-1:0]    full_re, full_im;
	logic                       clip_re, clip_im;
	logic                       tap_in_range;

	// bin mod MAX_BINS by reciprocal; exact for 10-bit bins, no correction step
	assign qprod = QP_W'(bin_q) * QP_W'(RECIP);
	assign qm    = QM_W'(binq_q) * QM_W'(MAX_BINS);
	assign rem   = QM_W'(bin_q) - qm;

	assign wr_addr   = slot_base_q + ADDR_W'(b_q);
	assign mem_we    = cmd.ring_wr | cmd.clr_wr;
	assign mem_addr  = cmd.clr_wr ? clr_addr_q : wr_addr;
	assign mem_wdata = cmd.clr_wr ? '0 : {rre_q, rim_q};

	assign tap_in_range = {1'b0, tidx_q} < (TIDX_W + 1)'(FILTER_ORDER);

	assign full_re = acc_re_q >>> FRAC_BITS;
	assign full_im = acc_im_q >>> FRAC_BITS;
	assign clip_re = (full_re > SAT_HI) || (full_re < SAT_LO);
	assign clip_im = (full_im > SAT_HI) || (full_im < SAT_LO);

	assign stat.is_bin      = (op_q == OP_BIN);
	assign stat.frame_start = fs_q;
	assign stat.clr_last    = (clr_addr_q == LAST_A);
	assign stat.k_last      = (k_q == LAST_K);
	assign stat.pipe_busy   = valid_s1 | valid_s2;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_addr] <= mem_wdata;
		end
		if (cmd.rd_step) begin
			{ref_re_s1, ref_im_s1} <= ring_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			tidx_q <= tap_index;
			tre_q  <= tap_real;
			tim_q  <= tap_imag;
			bin_q  <= bin_index;
			fs_q   <= frame_start;
			mre_q  <= mic_real;
			mim_q  <= mic_imag;
			rre_q  <= ref_real;
			rim_q  <= ref_imag;
		end
		if (cmd.tap_wr && tap_in_range) begin
			tap_re_q[tidx_q[IDX_W-1:0]] <= tre_q;
			tap_im_q[tidx_q[IDX_W-1:0]] <= tim_q;
		end
		if (cmd.mod_q) begin
			binq_q <= qprod[RCP_SH +: BIN_IN_W];
		end
		if (cmd.mod_r) begin
			b_q      <= rem[BIN_W-1:0];
			acc_re_q <= (SUM_W'(mre_q) <<< FRAC_BITS) + RND_BIAS;
			acc_im_q <= (SUM_W'(mim_q) <<< FRAC_BITS) + RND_BIAS;
		end else if (valid_s2) begin
			acc_re_q <= acc_re_q - SUM_W'(pr_rr_s2) + SUM_W'(pr_ii_s2);
			acc_im_q <= acc_im_q - SUM_W'(pr_ri_s2) - SUM_W'(pr_ir_s2);
		end
		if (cmd.rd_step) begin
			tap_re_s1 <= tap_re_q[k_q];
			tap_im_s1 <= tap_im_q[k_q];
		end
		pr_rr_s2 <= PROD_W'(tap_re_s1) * PROD_W'(ref_re_s1);
		pr_ii_s2 <= PROD_W'(tap_im_s1) * PROD_W'(ref_im_s1);
		pr_ri_s2 <= PROD_W'(tap_re_s1) * PROD_W'(ref_im_s1);
		pr_ir_s2 <= PROD_W'(tap_im_s1) * PROD_W'(ref_re_s1);
		if (cmd.out_load) begin
			out_bin <= bin_q;
			if (cmd.bypass) begin
				enh_real  <= mre_q;
				enh_imag  <= mim_q;
				saturated <= 1'b0;
			end else begin
				enh_real  <= clip_re ? (full_re > SAT_HI ? SAT_HI[SPEC_W-1:0] :
					SAT_LO[SPEC_W-1:0]) : full_re[SPEC_W-1:0];
				enh_imag  <= clip_im ? (full_im > SAT_HI ? SAT_HI[SPEC_W-1:0] :
					SAT_LO[SPEC_W-1:0]) : full_im[SPEC_W-1:0];
				saturated <= clip_re | clip_im;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			slot_base_q <= '0;
			rd_slot_q   <= '0;
			rd_addr_q   <= '0;
			k_q         <= '0;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_step;
			valid_s2 <= valid_s1;
			if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.slot_adv) begin
				if (slot_q == LAST_K) begin
					slot_q      <= '0;
					slot_base_q <= '0;
				end else begin
					slot_q      <= slot_q + 1'b1;
					slot_base_q <= slot_base_q + STEP_M;
				end
			end
			if (cmd.ring_wr) begin
				// k = 0 reads back the word just written
				rd_addr_q <= wr_addr;
				rd_slot_q <= slot_q;
				k_q       <= '0;
			end else if (cmd.rd_step) begin
				k_q <= k_q + 1'b1;
				if (rd_slot_q == '0) begin
					rd_slot_q <= LAST_K;
					rd_addr_q <= rd_addr_q + WRAP_M;
				end else begin
					rd_slot_q <= rd_slot_q - 1'b1;
					rd_addr_q <= rd_addr_q - STEP_M;
				end
			end
		end
	end

endmodule

@@ rtl/cmef_ctrl.sv @@
// Controller: sequences clear sweep, tap writes, bin processing and output handoff.
`timescale 1ns / 1ps

module cmef_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  cmef_pkg::stat_t   stat,
	output cmef_pkg::cmd_t    cmd
);
	import cmef_pkg::*;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_MODR  = 3'd3;
	localparam logic [2:0] S_WR    = 3'd4;
	localparam logic [2:0] S_RD    = 3'd5;
	localparam logic [2:0] S_DRAIN = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       filter_enable_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.bypass   = !filter_enable_q;
		cmd.load     = in_valid && in_ready;
		state_d      = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (!stat.is_bin) begin
					cmd.tap_wr = 1'b1;
					state_d    = S_IDLE;
				end else if (!filter_enable_q) begin
					state_d = S_OUT;
				end else begin
					cmd.slot_adv = stat.frame_start;
					cmd.mod_q    = 1'b1;
					state_d      = S_MODR;
				end
			end
			S_MODR: begin
				cmd.mod_r = 1'b1;
				state_d   = S_WR;
			end
			S_WR: begin
				cmd.ring_wr = 1'b1;
				state_d     = S_RD;
			end
			S_RD: begin
				cmd.rd_step = 1'b1;
				if (stat.k_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLR;
			filter_enable_q <= 1'b1;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				filter_enable_q <= cfg_data;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/complex_multiframe_echo_filter.sv @@
// Top level of the complex multi-frame echo filter.
//
//  channel | signals                          | carries
//  --------+----------------------------------+-------------------------------------
//  in      | in_valid / in_ready              | tap word or bin word (opcode selects)
//  out     | out_valid / out_ready            | one enhanced bin per bin word
//  cfg     | cfg_valid / cfg_ready, cfg_data  | filter_enable
//
// Bin word, filter on: one ring read and one complex MAC per tap, plus the bin-mod,
// ring write, two-stage multiply drain and output load.
// Tap word: decode, then tap write. Bin word with filter off: decode, then output load.
// After reset the ring is swept to zero while in_ready is low.
// A word waiting in the output register does not block the next input word;
// only its own output load waits for out_ready.
`timescale 1ns / 1ps

module complex_multiframe_echo_filter #(
	parameter int FILTER_ORDER = 5,
	parameter int MAX_BINS     = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   opcode,
	input  logic        [cmef_pkg::TIDX_W-1:0]     tap_index,
	input  logic signed [cmef_pkg::TAP_W-1:0]      tap_real,
	input  logic signed [cmef_pkg::TAP_W-1:0]      tap_imag,
	input  logic        [cmef_pkg::BIN_IN_W-1:0]   bin_index,
	input  logic                                   frame_start,
	input  logic signed [cmef_pkg::SPEC_W-1:0]     mic_real,
	input  logic signed [cmef_pkg::SPEC_W-1:0]     mic_imag,
	input  logic signed [cmef_pkg::SPEC_W-1:0]     ref_real,
	input  logic signed [cmef_pkg::SPEC_W-1:0]     ref_imag,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [cmef_pkg::BIN_IN_W-1:0]   out_bin,
	output logic signed [cmef_pkg::SPEC_W-1:0]     enh_real,
	output logic signed [cmef_pkg::SPEC_W-1:0]     enh_imag,
	output logic                                   saturated,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic                                   cfg_data
);
	import cmef_pkg::*;

	`include "complex_multiframe_echo_filter_macros.svh"

	cmd_t  cmd;
	stat_t stat;

	cmef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.cmd       (cmd)
	);

	cmef_dp #(
		.FILTER_ORDER (FILTER_ORDER),
		.MAX_BINS     (MAX_BINS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.tap_index   (tap_index),
		.tap_real    (tap_real),
		.tap_imag    (tap_imag),
		.bin_index   (bin_index),
		.frame_start (frame_start),
		.mic_real    (mic_real),
		.mic_imag    (mic_imag),
		.ref_real    (ref_real),
		.ref_imag    (ref_imag),
		.out_bin     (out_bin),
		.enh_real    (enh_real),
		.enh_imag    (enh_imag),
		.saturated   (saturated)
	);

	// one word in flight
	`CMEF_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "second word taken while busy")
	// a waiting result is never overwritten
	`CMEF_ASSERT_IMPL(a_out_no_overwrite, clk, arst_n, cmd.out_load, !out_valid || out_ready, "output overwritten")
	// first ring read directly follows the reference write
	`CMEF_ASSERT_NEXT(a_wr_then_read, clk, arst_n, cmd.ring_wr, cmd.rd_step, "ring read not after write")

endmodule
